FILE: hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
// No dependencies; every other file in hdl/ except sem_ram imports this package.
package sem_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  // Field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int MAG_W     = 8;
  localparam int GRAD_W    = 11;               // signed, |G| <= 4*255
  localparam int PROD_W    = 2*GRAD_W - 2;     // G^2 <= 1040400
  localparam int SUM_W     = PROD_W + 1;
  localparam int RAD_W     = 2*MAG_W;          // sqrt input range below saturation

  // Line store addressing and counter widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (EW_W > CFG_W) ? EW_W : CFG_W;
  localparam int ROW_W = CFG_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map and reset values
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = CFG_W'(256);

  // Operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_last;
  } out_word_t;

  // Gradient pair handed from front to back
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     frame_last;
  } grad_word_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

endpackage

FILE: hdl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sem_queue.sv
// Small register queue carrying gradient words from front to back.
// Depends on sem_pkg.
module sem_queue
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  grad_word_t wdata,
  input  logic       pop,
  output grad_word_t rdata,
  output q_stat_t    stat
);

  grad_word_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata       = mem_r[rd_ptr_r];
  assign stat.count  = count_r;
  assign stat.empty  = (count_r == '0);

endmodule

FILE: hdl/sem_front.sv
// Front end: takes pixel words, tracks the frame position, owns the line
// stores and the 3x3 window, and pushes gradient words. Depends on sem_pkg, sem_ram.
module sem_front
  import sem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_word_t             in_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output grad_word_t           q_wdata
);

  // configuration and position
  logic [CFG_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0] width_ext;
  logic [EW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h, h_p1, h_p2;

  logic             acc;
  logic             v_en, mid_en, top_en, at_c0, at_c1, emit, last, col_last;
  logic [PIX_W-1:0] pix_in;

  // stage 1: line store data arrives
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_top_en_r, s1_mid_en_r, s1_c0_r, s1_c1_r, s1_emit_r, s1_last_r;
  logic [COL_W-1:0] s1_addr_r;

  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
  logic [PIX_W-1:0]   top_px, mid_px;
  logic [PIX_W-1:0]   win_r   [9];
  logic [PIX_W-1:0]   win_nxt [9];
  logic [PIX_W-1:0]   p       [9];
  logic [GRAD_W-2:0]  sx_rgt, sx_lft, sy_b, sy_t;

  // effective frame size, clamped to the supported range
  always_comb begin
    width_ext = CMP_W'(width_r);
    if (width_ext < CMP_W'(MIN_DIM)) begin
      width_ext = CMP_W'(MIN_DIM);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_ext = CMP_W'(MAX_WIDTH);
    end
    eff_w = EW_W'(width_ext);

    eff_h = height_r;
    if (eff_h < ROW_W'(MIN_DIM)) begin
      eff_h = ROW_W'(MIN_DIM);
    end else if (eff_h > ROW_W'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end
    h_p1 = eff_h + ROW_W'(1);
    h_p2 = eff_h + ROW_W'(2);
  end

  // classify the incoming word against the current position
  assign acc      = in_push && !in_full;
  assign v_en     = (row_r < eff_h);
  assign mid_en   = (row_r >= ROW_W'(1)) && (row_r < h_p1);
  assign top_en   = (row_r >= ROW_W'(2)) && (row_r < h_p2);
  assign at_c0    = (col_r == '0);
  assign at_c1    = (col_r == COL_W'(1));
  assign emit     = at_c0 ? top_en : mid_en;
  assign last     = at_c0 && (row_r == h_p1);
  assign col_last = ((EW_W'(col_r) + EW_W'(1)) == eff_w);
  assign pix_in   = (in_word.operation == OP_PIXEL && v_en) ? in_word.pixel : '0;

  // room for the word in flight plus what the queue holds
  assign in_full = ((EW_W + QCNT_W)'(q_stat.count) + (EW_W + QCNT_W)'(s1_valid_r))
                   >= (EW_W + QCNT_W)'(QUEUE_DEPTH);

  // position advance; the bottom-right result restarts the frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CFG_DIM_RESET;
      height_r   <= CFG_DIM_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r    <= pix_in;
      s1_top_en_r <= top_en;
      s1_mid_en_r <= mid_en;
      s1_c0_r     <= at_c0;
      s1_c1_r     <= at_c1;
      s1_emit_r   <= emit;
      s1_last_r   <= last;
      s1_addr_r   <= col_r;
    end
  end

  // line stores: upper in the high byte, middle in the low byte
  sem_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign top_px    = s1_top_en_r ? ram_rdata[2*PIX_W-1:PIX_W] : '0;
  assign mid_px    = s1_mid_en_r ? ram_rdata[PIX_W-1:0] : '0;
  assign ram_wdata = {mid_px, s1_pix_r};

  // window shift: new column enters on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[3*k]     = win_r[3*k+1];
      win_nxt[3*k + 1] = win_r[3*k+2];
    end
    win_nxt[2] = top_px;
    win_nxt[5] = mid_px;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // zero the columns that fall outside the left or right edge
  always_comb begin
    p = win_nxt;
    if (s1_c1_r) begin
      p[0] = '0;
      p[3] = '0;
      p[6] = '0;
    end
    if (s1_c0_r) begin
      p[2] = '0;
      p[5] = '0;
      p[8] = '0;
    end
  end

  // Sobel kernels
  assign sx_rgt = (GRAD_W-1)'(p[2]) + ((GRAD_W-1)'(p[5]) << 1) + (GRAD_W-1)'(p[8]);
  assign sx_lft = (GRAD_W-1)'(p[0]) + ((GRAD_W-1)'(p[3]) << 1) + (GRAD_W-1)'(p[6]);
  assign sy_b   = (GRAD_W-1)'(p[6]) + ((GRAD_W-1)'(p[7]) << 1) + (GRAD_W-1)'(p[8]);
  assign sy_t   = (GRAD_W-1)'(p[0]) + ((GRAD_W-1)'(p[1]) << 1) + (GRAD_W-1)'(p[2]);

  assign q_push             = s1_valid_r && s1_emit_r;
  assign q_wdata.gx         = $signed({1'b0, sx_rgt}) - $signed({1'b0, sx_lft});
  assign q_wdata.gy         = $signed({1'b0, sy_b}) - $signed({1'b0, sy_t});
  assign q_wdata.frame_last = s1_last_r;

  // frame end returns the position to the top-left corner
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last && !cfg_write |=> (col_r == '0) && (row_r == '0))
    else $error("position not cleared after frame end");

  // row never runs past the drain row
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_p1)
    else $error("row counter beyond drain row");

  // a gradient word always finds room in the queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("gradient pushed into a full queue");

endmodule

FILE: hdl/sem_back.sv
// Back end: squares the gradients, sums them and takes a saturating
// integer square root, one bit per stage. Depends on sem_pkg.
module sem_back
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  grad_word_t q_rdata,
  input  q_stat_t    q_stat,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output out_word_t  out_word
);

  logic adv;

  // squaring stage
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic                       v1_r;
  logic [PROD_W-1:0]          sqx_r, sqy_r;
  logic                       last1_r;
  logic [SUM_W-1:0]           sum;

  // root stages: index 0 is the summed radicand, index MAG_W the result
  logic [MAG_W:0]     vld_r;
  logic [MAG_W:0]     sat_r;
  logic [MAG_W:0]     last_r;
  logic [RAD_W-1:0]   rad_r  [MAG_W+1];
  logic [RAD_W-1:0]   sq_r   [MAG_W+1];
  logic [MAG_W-1:0]   rt_r   [MAG_W+1];
  logic [RAD_W:0]     cand   [MAG_W];
  logic [RAD_W-1:0]   sq_nxt [MAG_W];
  logic [MAG_W-1:0]   rt_nxt [MAG_W];

  // whole pipeline moves unless the result register is held
  assign adv   = !vld_r[MAG_W] || out_pop;
  assign q_pop = adv && !q_stat.empty;

  assign gx_sq = q_rdata.gx * q_rdata.gx;
  assign gy_sq = q_rdata.gy * q_rdata.gy;
  assign sum   = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  // one root bit per stage: try (r+b)^2 = r^2 + 2rb + b^2
  always_comb begin
    for (int j = 0; j < MAG_W; j++) begin
      cand[j] = (RAD_W+1)'(sq_r[j])
              + ((RAD_W+1)'(rt_r[j]) << (MAG_W - j))
              + ((RAD_W+1)'(1) << (2*(MAG_W - 1 - j)));
      if (cand[j] <= (RAD_W+1)'(rad_r[j])) begin
        sq_nxt[j] = cand[j][RAD_W-1:0];
        rt_nxt[j] = rt_r[j] | (MAG_W'(1) << (MAG_W - 1 - j));
      end else begin
        sq_nxt[j] = sq_r[j];
        rt_nxt[j] = rt_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= '0;
    end else if (adv) begin
      v1_r  <= !q_stat.empty;
      vld_r <= {vld_r[MAG_W-1:0], v1_r};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r     <= gx_sq[PROD_W-1:0];
      sqy_r     <= gy_sq[PROD_W-1:0];
      last1_r   <= q_rdata.frame_last;
      rad_r[0]  <= sum[RAD_W-1:0];
      sat_r[0]  <= |sum[SUM_W-1:RAD_W];
      last_r[0] <= last1_r;
      sq_r[0]   <= '0;
      rt_r[0]   <= '0;
      for (int j = 0; j < MAG_W; j++) begin
        rad_r[j+1]  <= rad_r[j];
        sat_r[j+1]  <= sat_r[j];
        last_r[j+1] <= last_r[j];
        sq_r[j+1]   <= sq_nxt[j];
        rt_r[j+1]   <= rt_nxt[j];
      end
    end
  end

  assign out_empty           = !vld_r[MAG_W];
  assign out_word.magnitude  = sat_r[MAG_W] ? MAG_MAX : rt_r[MAG_W];
  assign out_word.frame_last = last_r[MAG_W];

endmodule

FILE: hdl/sobel_edge_magnitude_core.sv
// Top level of the Sobel edge magnitude core: front end, gradient queue, back end.
// Depends on sem_pkg, sem_front, sem_queue, sem_back (and sem_ram via sem_front).
//
//  channel | ports                              | word
//  --------+------------------------------------+-----------------------------
//  input   | in_push, in_full, in_word          | operation, pixel
//  result  | out_pop, out_empty, out_word       | magnitude, frame_last
//  config  | cfg_write, cfg_index, cfg_data     | image_width, image_height
//
// One input word per clock while in_full is low; the line store RAM has one read and one
// write per word, and the sqrt is pipelined one bit per stage.
// A result passes stage 1, the gradient queue, the squaring stage and the root
// stages after its window completes; it lags its pixel by one row plus one pixel.
// Reset clears position counters and sets both dimensions to 256; the line
// stores are not cleared, since rows outside the frame are masked to zero.
// A stalled result holds the back end; the 4-deep gradient queue lets the
// front keep taking words until it fills, then in_full rises.
module sobel_edge_magnitude_core
  import sem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_word_t             in_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_word_t            out_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic       q_push, q_pop;
  grad_word_t q_wdata, q_rdata;
  q_stat_t    q_stat;

  sem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sem_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
